// File: rtl/plfr_pkg.sv
// ----------------------------------------------------------------------------
// plfr_pkg: shared types, constants and microcode for the frame receiver
// Holds the parser phase type, the sequencer control word and its program.
// ----------------------------------------------------------------------------
package plfr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 26;

   localparam logic [7:0] HEAD_RESET = 8'hAA;
   localparam logic [7:0] ADDR_RESET = 8'hFF;

   localparam logic [7:0] FN_READ  = 8'hE1;
   localparam logic [7:0] FN_WRITE = 8'hE2;
   localparam logic [7:0] FN_CHECK = 8'h00;

   localparam logic [15:0] PID_SPEED = 16'd1;
   localparam logic [15:0] PID_TURNS = 16'd2;
   localparam logic [15:0] PID_TASK  = 16'd3;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEAD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ADDRESS = 1'd1;

   localparam logic [1:0] KIND_RX    = 2'd0;
   localparam logic [1:0] KIND_SPEED = 2'd1;
   localparam logic [1:0] KIND_TURNS = 2'd2;

   localparam int unsigned HEAD_DEPTH = 6;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_ADDR = 3'd1,
      PH_FUNC = 3'd2,
      PH_LEN  = 3'd3,
      PH_PAY  = 3'd4,
      PH_SUM  = 3'd5,
      PH_ADD  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_READ = 2'd1,
      ACT_ACK  = 2'd2
   } action_type;

   // frame fields the response programs read
   typedef struct packed {
      logic [7:0]                 fid;
      logic [7:0]                 rx_sum;
      logic [7:0]                 rx_add;
      logic [HEAD_DEPTH-1:0][7:0] pay;
   } frame_info_type;

   // one response beat
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
   } beat_type;

   typedef enum logic [3:0] {
      SRC_ZERO   = 4'd0,
      SRC_HEAD   = 4'd1,
      SRC_ADDR   = 4'd2,
      SRC_CONST  = 4'd3,
      SRC_ID_LO  = 4'd4,
      SRC_ID_HI  = 4'd5,
      SRC_REPLY0 = 4'd6,
      SRC_REPLY1 = 4'd7,
      SRC_REPLY2 = 4'd8,
      SRC_REPLY3 = 4'd9,
      SRC_FID    = 4'd10,
      SRC_RXSUM  = 4'd11,
      SRC_RXADD  = 4'd12,
      SRC_SUM    = 4'd13,
      SRC_ADD    = 4'd14
   } src_type;

   localparam int unsigned UC_PC_W = 5;

   // program entry points
   localparam logic [UC_PC_W-1:0] PC_BLANK    = 5'd0;
   localparam logic [UC_PC_W-1:0] PC_DISPATCH = 5'd1;
   localparam logic [UC_PC_W-1:0] PC_CHECK    = 5'd14;

   typedef struct packed {
      logic               emit;   // step hands a beat to the output
      logic               tx;     // beat carries a byte
      logic               clr;    // first byte of a frame, restart checks
      logic               acc;    // byte counts toward the checks
      logic               last;   // final step of the program
      logic               jmp;    // jump to target when not a read frame
      logic               load;   // latch the reply value
      src_type            src;
      logic [7:0]         cnst;
      logic [UC_PC_W-1:0] target;
   } uword_type;

   function automatic uword_type uw(input logic emit, input logic clr, input logic last,
                                    input src_type src, input logic [7:0] cnst);
      uword_type w;
      w.emit   = emit;
      w.tx     = emit;
      w.clr    = clr;
      w.acc    = emit && (src != SRC_SUM) && (src != SRC_ADD);
      w.last   = last;
      w.jmp    = 1'b0;
      w.load   = 1'b0;
      w.src    = src;
      w.cnst   = cnst;
      w.target = '0;
      return w;
   endfunction

   // response program rom
   function automatic uword_type ucode(input logic [UC_PC_W-1:0] pc);
      uword_type w;
      w = uw(1'b0, 1'b0, 1'b1, SRC_ZERO, 8'h00);
      case (pc)
         5'd0: begin
            w = uw(1'b1, 1'b0, 1'b1, SRC_ZERO, 8'h00);
            w.tx  = 1'b0;
            w.acc = 1'b0;
         end
         5'd1: begin
            w = uw(1'b0, 1'b0, 1'b0, SRC_ZERO, 8'h00);
            w.jmp    = 1'b1;
            w.load   = 1'b1;
            w.target = PC_CHECK;
         end
         // parameter frame
         5'd2:  w = uw(1'b1, 1'b1, 1'b0, SRC_HEAD,   8'h00);
         5'd3:  w = uw(1'b1, 1'b0, 1'b0, SRC_ADDR,   8'h00);
         5'd4:  w = uw(1'b1, 1'b0, 1'b0, SRC_CONST,  FN_WRITE);
         5'd5:  w = uw(1'b1, 1'b0, 1'b0, SRC_CONST,  8'd6);
         5'd6:  w = uw(1'b1, 1'b0, 1'b0, SRC_ID_LO,  8'h00);
         5'd7:  w = uw(1'b1, 1'b0, 1'b0, SRC_ID_HI,  8'h00);
         5'd8:  w = uw(1'b1, 1'b0, 1'b0, SRC_REPLY0, 8'h00);
         5'd9:  w = uw(1'b1, 1'b0, 1'b0, SRC_REPLY1, 8'h00);
         5'd10: w = uw(1'b1, 1'b0, 1'b0, SRC_REPLY2, 8'h00);
         5'd11: w = uw(1'b1, 1'b0, 1'b0, SRC_REPLY3, 8'h00);
         5'd12: w = uw(1'b1, 1'b0, 1'b0, SRC_SUM,    8'h00);
         5'd13: w = uw(1'b1, 1'b0, 1'b0, SRC_ADD,    8'h00);
         // check frame
         5'd14: w = uw(1'b1, 1'b1, 1'b0, SRC_HEAD,   8'h00);
         5'd15: w = uw(1'b1, 1'b0, 1'b0, SRC_ADDR,   8'h00);
         5'd16: w = uw(1'b1, 1'b0, 1'b0, SRC_CONST,  FN_CHECK);
         5'd17: w = uw(1'b1, 1'b0, 1'b0, SRC_CONST,  8'd3);
         5'd18: w = uw(1'b1, 1'b0, 1'b0, SRC_FID,    8'h00);
         5'd19: w = uw(1'b1, 1'b0, 1'b0, SRC_RXSUM,  8'h00);
         5'd20: w = uw(1'b1, 1'b0, 1'b0, SRC_RXADD,  8'h00);
         5'd21: w = uw(1'b1, 1'b0, 1'b0, SRC_SUM,    8'h00);
         5'd22: w = uw(1'b1, 1'b0, 1'b1, SRC_ADD,    8'h00);
         default: w = uw(1'b0, 1'b0, 1'b1, SRC_ZERO, 8'h00);
      endcase
      return w;
   endfunction

endpackage

// File: rtl/plfr_if.sv
// ----------------------------------------------------------------------------
// plfr channel interfaces
// Input item, response beat and register write channels.
// ----------------------------------------------------------------------------
interface plfr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         rx_byte;
   logic signed [31:0] update_value;

   modport source (output valid, output kind, output rx_byte, output update_value,
                   input ready);
   modport sink   (input valid, input kind, input rx_byte, input update_value,
                   output ready);
endinterface

interface plfr_rsp_if;
   logic               valid;
   logic               ready;
   logic               tx_valid;
   logic [7:0]         tx_byte;
   logic               tx_last;
   logic signed [31:0] speed_now;
   logic signed [31:0] turns_now;
   logic signed [31:0] task_now;
   logic               task_restart;

   modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                   output speed_now, output turns_now, output task_now,
                   output task_restart, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input tx_last,
                   input speed_now, input turns_now, input task_now,
                   input task_restart, output ready);
endinterface

interface plfr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [plfr_pkg::CSR_IDX_W-1:0]     index;
   logic [7:0]                         data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/plfr_parser.sv
// ----------------------------------------------------------------------------
// plfr_parser: receive frame parser and parameter store
// Walks frame phases one byte per item and applies valid write frames.
// ----------------------------------------------------------------------------
module plfr_parser #(
   parameter int unsigned MAX_PAYLOAD = plfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_go,
   input  logic [1:0]               kind,
   input  logic [7:0]               rx_byte,
   input  logic [31:0]              update_value,
   input  logic [7:0]               frame_head,
   output plfr_pkg::action_type     action,
   output plfr_pkg::frame_info_type info,
   output logic [31:0]              speed,
   output logic [31:0]              turns,
   output logic [31:0]              task_val,
   output logic                     restart
);

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   plfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  fid_ff, fid_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  add_ff, add_in;
   logic [7:0]  rxsum_ff, rxsum_in;
   logic [7:0]  rxadd_ff, rxadd_in;
   logic [plfr_pkg::HEAD_DEPTH-1:0][7:0] head_ff, head_in;
   logic [31:0] speed_ff, speed_in;
   logic [31:0] turns_ff, turns_in;
   logic [31:0] task_ff, task_in;
   logic        restart_ff, restart_in;

   logic        rx_go;
   logic [7:0]  sum_abs;
   logic [7:0]  add_abs;
   logic [15:0] pid;
   logic [31:0] pval;

   assign rx_go   = item_go && (kind == plfr_pkg::KIND_RX);
   assign sum_abs = sum_ff + rx_byte;
   assign add_abs = add_ff + sum_abs;
   assign pid     = {head_ff[1], head_ff[0]};
   assign pval    = {head_ff[5], head_ff[4], head_ff[3], head_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= plfr_pkg::PH_HUNT;
         length_ff  <= '0;
         count_ff   <= '0;
         fid_ff     <= '0;
         sum_ff     <= '0;
         add_ff     <= '0;
         rxsum_ff   <= '0;
         rxadd_ff   <= '0;
         head_ff    <= '0;
         speed_ff   <= '0;
         turns_ff   <= '0;
         task_ff    <= '0;
         restart_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         fid_ff     <= fid_in;
         sum_ff     <= sum_in;
         add_ff     <= add_in;
         rxsum_ff   <= rxsum_in;
         rxadd_ff   <= rxadd_in;
         head_ff    <= head_in;
         speed_ff   <= speed_in;
         turns_ff   <= turns_in;
         task_ff    <= task_in;
         restart_ff <= restart_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      fid_in     = fid_ff;
      sum_in     = sum_ff;
      add_in     = add_ff;
      rxsum_in   = rxsum_ff;
      rxadd_in   = rxadd_ff;
      head_in    = head_ff;
      speed_in   = speed_ff;
      turns_in   = turns_ff;
      task_in    = task_ff;
      restart_in = item_go ? 1'b0 : restart_ff;
      action     = plfr_pkg::ACT_NONE;

      if (item_go && (kind == plfr_pkg::KIND_SPEED)) begin
         speed_in = update_value;
      end
      if (item_go && (kind == plfr_pkg::KIND_TURNS)) begin
         turns_in = update_value;
      end

      if (rx_go) begin
         case (phase_ff)
            plfr_pkg::PH_ADDR: begin
               sum_in   = sum_abs;
               add_in   = add_abs;
               phase_in = plfr_pkg::PH_FUNC;
            end
            plfr_pkg::PH_FUNC: begin
               sum_in   = sum_abs;
               add_in   = add_abs;
               fid_in   = rx_byte;
               phase_in = plfr_pkg::PH_LEN;
            end
            plfr_pkg::PH_LEN: begin
               if (rx_byte > MaxLen) begin
                  phase_in = plfr_pkg::PH_HUNT;
               end else begin
                  sum_in    = sum_abs;
                  add_in    = add_abs;
                  length_in = rx_byte;
                  count_in  = '0;
                  phase_in  = (rx_byte == 8'd0) ? plfr_pkg::PH_SUM : plfr_pkg::PH_PAY;
               end
            end
            plfr_pkg::PH_PAY: begin
               sum_in = sum_abs;
               add_in = add_abs;
               if (count_ff < 8'(plfr_pkg::HEAD_DEPTH)) begin
                  head_in[count_ff[2:0]] = rx_byte;
               end
               count_in = count_ff + 8'd1;
               if (count_in >= length_ff) begin
                  phase_in = plfr_pkg::PH_SUM;
               end
            end
            plfr_pkg::PH_SUM: begin
               rxsum_in = rx_byte;
               phase_in = plfr_pkg::PH_ADD;
            end
            plfr_pkg::PH_ADD: begin
               phase_in = plfr_pkg::PH_HUNT;
               rxadd_in = rx_byte;
               if ((rxsum_ff == sum_ff) && (rx_byte == add_ff)) begin
                  if (fid_ff == plfr_pkg::FN_READ) begin
                     action = plfr_pkg::ACT_READ;
                  end else begin
                     action = plfr_pkg::ACT_ACK;
                  end
                  if (fid_ff == plfr_pkg::FN_WRITE) begin
                     if (pid == plfr_pkg::PID_SPEED) begin
                        speed_in = pval;
                     end else if (pid == plfr_pkg::PID_TURNS) begin
                        turns_in = pval;
                     end else if (pid == plfr_pkg::PID_TASK) begin
                        task_in    = pval;
                        restart_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // hunting, also any unused phase code
               phase_in = plfr_pkg::PH_HUNT;
               if (rx_byte == frame_head) begin
                  head_in   = '0;
                  length_in = '0;
                  count_in  = '0;
                  sum_in    = rx_byte;
                  add_in    = rx_byte;
                  phase_in  = plfr_pkg::PH_ADDR;
               end
            end
         endcase
      end
   end

   assign info.fid    = fid_ff;
   assign info.rx_sum = rxsum_ff;
   assign info.rx_add = rxadd_ff;
   assign info.pay    = head_ff;
   assign speed       = speed_ff;
   assign turns       = turns_ff;
   assign task_val    = task_ff;
   assign restart     = restart_ff;

endmodule

// File: rtl/plfr_sequencer.sv
// ----------------------------------------------------------------------------
// plfr_sequencer: microcoded response generator
// Steps through the response program rom and builds frame bytes and checks.
// ----------------------------------------------------------------------------
module plfr_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     is_frame,
   input  logic                     is_read,
   input  plfr_pkg::frame_info_type info,
   input  logic [31:0]              speed,
   input  logic [31:0]              turns,
   input  logic [7:0]               frame_head,
   input  logic [7:0]               own_address,
   input  logic                     out_free,
   output logic                     busy,
   output logic                     beat_go,
   output plfr_pkg::beat_type       beat
);

   logic [plfr_pkg::UC_PC_W-1:0] pc_ff, pc_in;
   logic                         busy_ff, busy_in;
   logic                         read_ff, read_in;
   logic [31:0]                  reply_ff, reply_in;
   logic [7:0]                   sc_ff, sc_in;
   logic [7:0]                   ac_ff, ac_in;

   plfr_pkg::uword_type word;
   logic        advance;
   logic [7:0]  data;
   logic [7:0]  sc_next;
   logic [15:0] pid;
   logic [31:0] turns_x10;

   assign word      = plfr_pkg::ucode(pc_ff);
   assign advance   = busy_ff && (!word.emit || out_free);
   assign pid       = {info.pay[1], info.pay[0]};
   assign turns_x10 = {turns[28:0], 3'b000} + {turns[30:0], 1'b0};

   always_comb begin
      case (word.src)
         plfr_pkg::SRC_HEAD:   data = frame_head;
         plfr_pkg::SRC_ADDR:   data = own_address;
         plfr_pkg::SRC_CONST:  data = word.cnst;
         plfr_pkg::SRC_ID_LO:  data = info.pay[0];
         plfr_pkg::SRC_ID_HI:  data = info.pay[1];
         plfr_pkg::SRC_REPLY0: data = reply_ff[7:0];
         plfr_pkg::SRC_REPLY1: data = reply_ff[15:8];
         plfr_pkg::SRC_REPLY2: data = reply_ff[23:16];
         plfr_pkg::SRC_REPLY3: data = reply_ff[31:24];
         plfr_pkg::SRC_FID:    data = info.fid;
         plfr_pkg::SRC_RXSUM:  data = info.rx_sum;
         plfr_pkg::SRC_RXADD:  data = info.rx_add;
         plfr_pkg::SRC_SUM:    data = sc_ff;
         plfr_pkg::SRC_ADD:    data = ac_ff;
         default:              data = 8'h00;
      endcase
   end

   assign sc_next = word.clr ? data : (sc_ff + data);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= plfr_pkg::PC_BLANK;
         busy_ff <= 1'b0;
         read_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
         read_ff <= read_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
      sc_ff    <= sc_in;
      ac_ff    <= ac_in;
   end

   always_comb begin
      pc_in    = pc_ff;
      busy_in  = busy_ff;
      read_in  = read_ff;
      reply_in = reply_ff;
      sc_in    = sc_ff;
      ac_in    = ac_ff;
      if (start) begin
         busy_in = 1'b1;
         read_in = is_read;
         pc_in   = is_frame ? plfr_pkg::PC_DISPATCH : plfr_pkg::PC_BLANK;
      end else if (advance) begin
         if (word.load) begin
            if (pid == plfr_pkg::PID_SPEED) begin
               reply_in = speed;
            end else if (pid == plfr_pkg::PID_TURNS) begin
               reply_in = turns_x10;
            end else begin
               reply_in = '0;
            end
         end
         if (word.acc) begin
            sc_in = sc_next;
            ac_in = word.clr ? data : (ac_ff + sc_next);
         end
         if (word.last) begin
            busy_in = 1'b0;
         end else if (word.jmp && !read_ff) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 5'd1;
         end
      end
   end

   assign busy          = busy_ff;
   assign beat_go       = advance && word.emit;
   assign beat.tx_valid = word.tx;
   assign beat.tx_byte  = word.tx ? data : 8'h00;
   assign beat.tx_last  = word.last;

endmodule

// File: rtl/param_link_frame_receiver.sv
// ----------------------------------------------------------------------------
// param_link_frame_receiver: parameter link frame receiver
// Parses framed parameter reads and writes from a serial byte stream and
// builds parameter and check response frames as output beats.
// ----------------------------------------------------------------------------
// response: each item taken starts the sequencer, whose first beat is registered in
//   the output register, after one sequencer dispatch step for a completed frame
// items: a new item is taken only after the sequencer has issued every beat of the
//   last, one beat per cycle while the output register can take it: a check frame for
//   an acknowledged frame, a parameter then a check frame for a read, else a blank beat
// reset: synchronous, clears parser, stored values and registers to their
//   defaults (head 0xaa, address 0xff); no clearing pass
module param_link_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD = plfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   plfr_req_if.sink   req_bus,
   plfr_rsp_if.source rsp_bus,
   plfr_csr_if.sink   csr_bus
);

   // register file
   logic [7:0] head_ff, head_in;
   logic [7:0] addr_ff, addr_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   plfr_pkg::beat_type beat_ff, beat_in;
   logic [31:0]       speed_ff, speed_in;
   logic [31:0]       turns_ff, turns_in;
   logic [31:0]       task_ff, task_in;
   logic              restart_ff, restart_in;

   logic                     item_go;
   logic                     csr_go;
   logic                     out_free;
   logic                     seq_busy;
   logic                     beat_go;
   plfr_pkg::beat_type       beat;
   plfr_pkg::action_type     action;
   plfr_pkg::frame_info_type info;
   logic [31:0]              speed;
   logic [31:0]              turns;
   logic [31:0]              task_val;
   logic                     restart;

   // items are taken only out of reset and when the sequencer has no beats left
   assign req_bus.ready = !seq_busy && !reset;
   assign item_go       = req_bus.valid && req_bus.ready;

   // register writes are taken whenever out of reset
   assign csr_bus.ready = !reset;
   assign csr_go        = csr_bus.valid && csr_bus.ready;

   // output register can take a beat when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= plfr_pkg::HEAD_RESET;
         addr_ff      <= plfr_pkg::ADDR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff    <= beat_in;
      speed_ff   <= speed_in;
      turns_ff   <= turns_in;
      task_ff    <= task_in;
      restart_ff <= restart_in;
   end

   always_comb begin
      head_in = head_ff;
      addr_in = addr_ff;
      if (csr_go) begin
         case (csr_bus.index)
            plfr_pkg::REG_FRAME_HEAD:  head_in = csr_bus.data;
            plfr_pkg::REG_OWN_ADDRESS: addr_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // beat capture: stored values are already those after the current item
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      beat_in      = beat_ff;
      speed_in     = speed_ff;
      turns_in     = turns_ff;
      task_in      = task_ff;
      restart_in   = restart_ff;
      if (beat_go) begin
         rsp_valid_in = 1'b1;
         beat_in      = beat;
         speed_in     = speed;
         turns_in     = turns;
         task_in      = task_val;
         restart_in   = restart;
      end
   end

   plfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_go      (item_go),
      .kind         (req_bus.kind),
      .rx_byte      (req_bus.rx_byte),
      .update_value (req_bus.update_value),
      .frame_head   (head_ff),
      .action       (action),
      .info         (info),
      .speed        (speed),
      .turns        (turns),
      .task_val     (task_val),
      .restart      (restart)
   );

   // every item starts a program: blank beat, or dispatch for a good frame
   plfr_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (item_go),
      .is_frame    (action != plfr_pkg::ACT_NONE),
      .is_read     (action == plfr_pkg::ACT_READ),
      .info        (info),
      .speed       (speed),
      .turns       (turns),
      .frame_head  (head_ff),
      .own_address (addr_ff),
      .out_free    (out_free),
      .busy        (seq_busy),
      .beat_go     (beat_go),
      .beat        (beat)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tx_valid     = beat_ff.tx_valid;
   assign rsp_bus.tx_byte      = beat_ff.tx_byte;
   assign rsp_bus.tx_last      = beat_ff.tx_last;
   assign rsp_bus.speed_now    = speed_ff;
   assign rsp_bus.turns_now    = turns_ff;
   assign rsp_bus.task_now     = task_ff;
   assign rsp_bus.task_restart = restart_ff;

endmodule
